[hdl/sps_pkg.sv]
// types, character codes and phase tables for the stepper phase sequencer
// no dependencies
`default_nettype none

package sps_pkg;

  typedef enum logic [1:0] {
    RUN_STOP = 2'd0,
    RUN_FWD  = 2'd1,
    RUN_BWD  = 2'd2
  } run_req_t;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_FULL = 2'd1,
    MODE_HALF = 2'd2,
    MODE_WAVE = 2'd3
  } mode_t;

  localparam logic [7:0] CH_FWD    = 8'h61;  // a
  localparam logic [7:0] CH_BWD    = 8'h64;  // d
  localparam logic [7:0] CH_STOP   = 8'h73;  // s
  localparam logic [7:0] CH_FULL   = 8'h65;  // e
  localparam logic [7:0] CH_HALF   = 8'h71;  // q
  localparam logic [7:0] CH_WAVE   = 8'h77;  // w
  localparam logic [7:0] CH_SINGLE = 8'h7a;  // z
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [4:0] TICK_MAX  = 5'd31;
  localparam logic [4:0] HOLD_MIN  = 5'd1;

  localparam int OUT_W = 16;

  // hold ticks for digits one to nine: 18, 16, ... 2
  function automatic logic [4:0] hold_for_digit(input logic [3:0] d);
    logic [4:0] h;
    case (d)
      4'd1:    h = 5'd18;
      4'd2:    h = 5'd16;
      4'd3:    h = 5'd14;
      4'd4:    h = 5'd12;
      4'd5:    h = 5'd10;
      4'd6:    h = 5'd8;
      4'd7:    h = 5'd6;
      4'd8:    h = 5'd4;
      4'd9:    h = 5'd2;
      default: h = 5'd1;
    endcase
    return h;
  endfunction

  function automatic logic [2:0] last_phase(input mode_t m);
    return (m == MODE_HALF) ? 3'd7 : 3'd3;
  endfunction

  function automatic logic [3:0] coil_lookup(input mode_t m, input logic bwd,
                                             input logic [2:0] ph);
    logic [3:0] c;
    c = 4'h0;
    case (m)
      MODE_FULL: begin
        case (ph[1:0])
          2'd0:    c = bwd ? 4'h3 : 4'h9;
          2'd1:    c = bwd ? 4'h6 : 4'hC;
          2'd2:    c = bwd ? 4'hC : 4'h6;
          default: c = bwd ? 4'h9 : 4'h3;
        endcase
      end
      MODE_HALF: begin
        case (ph)
          3'd0:    c = 4'h1;
          3'd1:    c = bwd ? 4'h3 : 4'h9;
          3'd2:    c = bwd ? 4'h2 : 4'h8;
          3'd3:    c = bwd ? 4'h6 : 4'hC;
          3'd4:    c = 4'h4;
          3'd5:    c = bwd ? 4'hC : 4'h6;
          3'd6:    c = bwd ? 4'h8 : 4'h2;
          default: c = bwd ? 4'h9 : 4'h3;
        endcase
      end
      MODE_WAVE: begin
        case (ph[1:0])
          2'd0:    c = 4'h1;
          2'd1:    c = bwd ? 4'h2 : 4'h8;
          2'd2:    c = 4'h4;
          default: c = bwd ? 4'h8 : 4'h2;
        endcase
      end
      default: c = 4'h0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[hdl/stepper_phase_sequencer.sv]
// stepper_phase_sequencer: top level, command decode, phase timing and result register
// depends on sps_pkg
//
// usage:
// the slave channel carries one item per transfer: s_axis_tuser is 0 for a
// one millisecond tick and 1 for a received command byte in s_axis_tdata.
// every accepted item produces exactly one transfer on the master channel
// with the coil drive bits, led level, echo of the byte, help flag and the
// running status as they stand after that item.
// the result is valid in the cycle after the input transfer. one item is
// taken per cycle while the receiver keeps up: the state update and the result
// are computed in the accepting cycle and land in a single output register.
// when the receiver stalls with a result held, s_axis_tready drops until
// the result is taken; nothing is lost or repeated.
// synchronous reset stops the motor, clears the mode, sets the hold time to
// one tick, clears the led and empties the output register.
`default_nettype none

module stepper_phase_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // cmd_byte
  input  wire logic        s_axis_tuser,   // opcode
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [sps_pkg::OUT_W-1:0] m_axis_tdata,
  // coil_pattern[3:0], led_on[4], echo_byte[12:5], help_flag[13], running[14], zero[15]
  output      logic        m_axis_tuser    // echo_valid
);

  sps_pkg::run_req_t run_request, run_request_next;
  sps_pkg::mode_t    mode_request, mode_request_next;
  sps_pkg::mode_t    active_mode, active_mode_next;
  logic [4:0] hold_ticks, hold_ticks_next;
  logic [4:0] tick_count, tick_count_next;
  logic [2:0] phase_index, phase_index_next;
  logic       single_pass, single_pass_next;
  logic       active, active_next;
  logic       active_direction, active_direction_next;
  logic       led_level, led_level_next;
  logic       led_pin, led_pin_next;
  logic       help;
  logic       xfer;
  logic [sps_pkg::OUT_W-1:0] result;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign xfer          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    logic [4:0] tinc;
    logic       keep;
    run_request_next      = run_request;
    mode_request_next     = mode_request;
    active_mode_next      = active_mode;
    hold_ticks_next       = hold_ticks;
    tick_count_next       = tick_count;
    phase_index_next      = phase_index;
    single_pass_next      = single_pass;
    active_next           = active;
    active_direction_next = active_direction;
    led_level_next        = led_level;
    led_pin_next          = led_pin;
    help                  = 1'b0;
    tinc                  = (tick_count < sps_pkg::TICK_MAX) ? tick_count + 5'd1 : tick_count;
    keep                  = 1'b0;

    if (s_axis_tuser) begin
      case (s_axis_tdata)
        sps_pkg::CH_FWD: begin
          run_request_next = sps_pkg::RUN_FWD;
          led_pin_next     = 1'b1;
        end
        sps_pkg::CH_BWD: begin
          run_request_next = sps_pkg::RUN_BWD;
          led_pin_next     = 1'b1;
        end
        sps_pkg::CH_STOP: begin
          run_request_next = sps_pkg::RUN_STOP;
          led_pin_next     = 1'b0;
        end
        sps_pkg::CH_FULL:   mode_request_next = sps_pkg::MODE_FULL;
        sps_pkg::CH_HALF:   mode_request_next = sps_pkg::MODE_HALF;
        sps_pkg::CH_WAVE:   mode_request_next = sps_pkg::MODE_WAVE;
        sps_pkg::CH_SINGLE: single_pass_next  = 1'b1;
        sps_pkg::CH_ZERO:   hold_ticks_next   = sps_pkg::HOLD_MIN;
        default: begin
          if (s_axis_tdata >= sps_pkg::CH_ONE && s_axis_tdata <= sps_pkg::CH_NINE) begin
            hold_ticks_next = sps_pkg::hold_for_digit(s_axis_tdata[3:0]);
          end else begin
            help = 1'b1;
          end
        end
      endcase
    end else if (active) begin
      if (tinc < hold_ticks) begin
        tick_count_next = tinc;
      end else begin
        tick_count_next = 5'd0;
        if (phase_index != sps_pkg::last_phase(active_mode)) begin
          phase_index_next = phase_index + 3'd1;
        end else begin
          phase_index_next = 3'd0;
          led_level_next   = !led_level;
          led_pin_next     = !led_level;
          if (single_pass) begin
            run_request_next = sps_pkg::RUN_STOP;
            single_pass_next = 1'b0;
          end
          keep = (run_request_next == sps_pkg::RUN_FWD && !active_direction) ||
                 (run_request_next == sps_pkg::RUN_BWD && active_direction);
          if (!keep) begin
            active_next = 1'b0;
          end
        end
      end
    end

    // start rule after every item
    if (!active_next &&
        (run_request_next == sps_pkg::RUN_FWD || run_request_next == sps_pkg::RUN_BWD) &&
        mode_request_next != sps_pkg::MODE_NONE) begin
      active_next           = 1'b1;
      active_direction_next = (run_request_next == sps_pkg::RUN_BWD);
      active_mode_next      = mode_request_next;
      phase_index_next      = 3'd0;
      tick_count_next       = 5'd0;
    end
  end

  always_comb begin
    result        = '0;
    result[3:0]   = active_next ?
                    sps_pkg::coil_lookup(active_mode_next, active_direction_next,
                                         phase_index_next) : 4'h0;
    result[4]     = led_pin_next;
    result[12:5]  = s_axis_tuser ? s_axis_tdata : 8'h00;
    result[13]    = s_axis_tuser && help;
    result[14]    = active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_request      <= sps_pkg::RUN_STOP;
      mode_request     <= sps_pkg::MODE_NONE;
      active_mode      <= sps_pkg::MODE_NONE;
      hold_ticks       <= sps_pkg::HOLD_MIN;
      tick_count       <= 5'd0;
      phase_index      <= 3'd0;
      single_pass      <= 1'b0;
      active           <= 1'b0;
      active_direction <= 1'b0;
      led_level        <= 1'b0;
      led_pin          <= 1'b0;
      m_axis_tvalid    <= 1'b0;
    end else begin
      if (xfer) begin
        run_request      <= run_request_next;
        mode_request     <= mode_request_next;
        active_mode      <= active_mode_next;
        hold_ticks       <= hold_ticks_next;
        tick_count       <= tick_count_next;
        phase_index      <= phase_index_next;
        single_pass      <= single_pass_next;
        active           <= active_next;
        active_direction <= active_direction_next;
        led_level        <= led_level_next;
        led_pin          <= led_pin_next;
        m_axis_tvalid    <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid    <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (xfer) begin
      m_axis_tdata <= result;
      m_axis_tuser <= s_axis_tuser;
    end
  end

endmodule

`default_nettype wire

[tb/tb_stepper_phase_sequencer.sv]
// self-checking testbench for stepper_phase_sequencer: ticks and command bytes in,
// coil, led, echo and status words checked against a cycle-free behavioral predictor
// depends on sps_pkg and the stepper_phase_sequencer rtl
`timescale 1ns / 1ps

module tb_stepper_phase_sequencer;

  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_PER_PHASE = 650;
  localparam int MAX_PRINTED = 40;

  // phase tables, first phase in the lowest nibble
  localparam logic [15:0] FULL_FWD_TBL = 16'h36C9;
  localparam logic [15:0] FULL_BWD_TBL = 16'h9C63;
  localparam logic [31:0] HALF_FWD_TBL = 32'h3264C891;
  localparam logic [31:0] HALF_BWD_TBL = 32'h98C46231;
  localparam logic [15:0] WAVE_FWD_TBL = 16'h2481;
  localparam logic [15:0] WAVE_BWD_TBL = 16'h8421;

  typedef struct packed {
    logic       is_cmd;
    logic [7:0] ch;
  } host_item_t;

  typedef struct packed {
    logic [3:0] coil;
    logic       led;
    logic       echo_valid;
    logic [7:0] echo;
    logic       help;
    logic       running;
  } drive_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = 8'd0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [sps_pkg::OUT_W-1:0] m_axis_tdata;
  logic m_axis_tuser;

  stepper_phase_sequencer dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  host_item_t  host_queue[$];
  drive_word_t predicted_drive[$];
  host_item_t  in_flight;
  drive_word_t want;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int errors = 0;
  int results_checked = 0;
  int ticks_sent = 0;
  int cmds_sent = 0;
  int help_bytes = 0;
  int passes_done = 0;
  int quiet_cycles = 0;

  // motor state as the block should hold it
  sps_pkg::run_req_t run_req = sps_pkg::RUN_STOP;
  sps_pkg::mode_t    mode_req = sps_pkg::MODE_NONE;
  logic [4:0] hold = sps_pkg::HOLD_MIN;
  logic       single = 1'b0;
  logic       act = 1'b0;
  logic       act_bwd = 1'b0;
  sps_pkg::mode_t    act_mode = sps_pkg::MODE_NONE;
  logic [2:0] phase = 3'd0;
  logic [4:0] ticks = 5'd0;
  logic       led_lvl = 1'b0;
  logic       led_drv = 1'b0;

  function automatic drive_word_t sequence_step(input host_item_t it);
    drive_word_t r;
    logic help;
    logic [2:0] last;
    help = 1'b0;
    if (it.is_cmd) begin
      cmds_sent++;
      case (it.ch)
        sps_pkg::CH_FWD: begin
          run_req = sps_pkg::RUN_FWD;
          led_drv = 1'b1;
        end
        sps_pkg::CH_BWD: begin
          run_req = sps_pkg::RUN_BWD;
          led_drv = 1'b1;
        end
        sps_pkg::CH_STOP: begin
          run_req = sps_pkg::RUN_STOP;
          led_drv = 1'b0;
        end
        sps_pkg::CH_FULL:   mode_req = sps_pkg::MODE_FULL;
        sps_pkg::CH_HALF:   mode_req = sps_pkg::MODE_HALF;
        sps_pkg::CH_WAVE:   mode_req = sps_pkg::MODE_WAVE;
        sps_pkg::CH_SINGLE: single = 1'b1;
        default: begin
          if (it.ch == sps_pkg::CH_ZERO)
            hold = sps_pkg::HOLD_MIN;
          else if (it.ch >= sps_pkg::CH_ONE && it.ch <= sps_pkg::CH_NINE)
            hold = 5'(18 - 2 * int'(it.ch - sps_pkg::CH_ONE));
          else
            help = 1'b1;
        end
      endcase
      if (help) help_bytes++;
    end else begin
      ticks_sent++;
      if (act) begin
        if (ticks != sps_pkg::TICK_MAX) ticks = ticks + 5'd1;
        if (ticks >= hold) begin
          ticks = 5'd0;
          last = (act_mode == sps_pkg::MODE_HALF) ? 3'd7 : 3'd3;
          if (phase != last) begin
            phase = phase + 3'd1;
          end else begin
            phase = 3'd0;
            passes_done++;
            led_lvl = ~led_lvl;
            led_drv = led_lvl;
            if (single) begin
              run_req = sps_pkg::RUN_STOP;
              single = 1'b0;
            end
            if (run_req != (act_bwd ? sps_pkg::RUN_BWD : sps_pkg::RUN_FWD)) act = 1'b0;
          end
        end
      end
    end
    if (!act && (run_req == sps_pkg::RUN_FWD || run_req == sps_pkg::RUN_BWD) &&
        mode_req != sps_pkg::MODE_NONE) begin
      act = 1'b1;
      act_bwd = (run_req == sps_pkg::RUN_BWD);
      act_mode = mode_req;
      phase = 3'd0;
      ticks = 5'd0;
    end
    r.coil = 4'h0;
    if (act) begin
      case (act_mode)
        sps_pkg::MODE_FULL: r.coil = act_bwd ? FULL_BWD_TBL[4*phase[1:0] +: 4]
                                             : FULL_FWD_TBL[4*phase[1:0] +: 4];
        sps_pkg::MODE_HALF: r.coil = act_bwd ? HALF_BWD_TBL[4*phase +: 4]
                                             : HALF_FWD_TBL[4*phase +: 4];
        sps_pkg::MODE_WAVE: r.coil = act_bwd ? WAVE_BWD_TBL[4*phase[1:0] +: 4]
                                             : WAVE_FWD_TBL[4*phase[1:0] +: 4];
        default:            r.coil = 4'h0;
      endcase
    end
    r.led = led_drv;
    r.echo_valid = it.is_cmd;
    r.echo = it.is_cmd ? it.ch : 8'd0;
    r.help = it.is_cmd && help;
    r.running = act;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    if (got != exp_val) begin
      errors++;
      if (errors <= MAX_PRINTED)
        $display("%0t: %s mismatch, got 0x%0h want 0x%0h", $time, what, got, exp_val);
    end
  endtask

  // driver: predicts each accepted transfer, then offers the next item
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        predicted_drive.push_back(sequence_step(in_flight));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (host_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_flight = host_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= in_flight.is_cmd;
          s_axis_tdata <= in_flight.ch;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (predicted_drive.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, -1);
      end else begin
        want = predicted_drive.pop_front();
        results_checked++;
        report_mismatch("coil_pattern", m_axis_tdata[3:0], want.coil);
        report_mismatch("led_on", m_axis_tdata[4], want.led);
        report_mismatch("echo_byte", m_axis_tdata[12:5], want.echo);
        report_mismatch("help_flag", m_axis_tdata[13], want.help);
        report_mismatch("running", m_axis_tdata[14], want.running);
        report_mismatch("pad bit", m_axis_tdata[15], 0);
        report_mismatch("echo_valid", m_axis_tuser, want.echo_valid);
      end
    end
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("timeout with %0d results outstanding", predicted_drive.size());
      $display("stepper_phase_sequencer regression: fail");
      $finish;
    end
  end

  task automatic queue_item(input logic is_cmd, input logic [7:0] ch);
    host_item_t it;
    it.is_cmd = is_cmd;
    it.ch = ch;
    host_queue.push_back(it);
  endtask

  task automatic drain;
    while (host_queue.size() != 0 || s_axis_tvalid || predicted_drive.size() != 0)
      @(negedge clk);
  endtask

  task automatic queue_random_item;
    int r;
    int k;
    r = $urandom_range(99);
    k = $urandom_range(15);
    if (r < 62) begin
      queue_item(1'b0, 8'($urandom_range(255)));
    end else if (r < 94) begin
      case (k)
        0, 1:    queue_item(1'b1, sps_pkg::CH_FWD);
        2, 3:    queue_item(1'b1, sps_pkg::CH_BWD);
        4:       queue_item(1'b1, sps_pkg::CH_STOP);
        5:       queue_item(1'b1, sps_pkg::CH_FULL);
        6:       queue_item(1'b1, sps_pkg::CH_HALF);
        7:       queue_item(1'b1, sps_pkg::CH_WAVE);
        8:       queue_item(1'b1, sps_pkg::CH_SINGLE);
        default: queue_item(1'b1, $urandom_range(1) ? sps_pkg::CH_ZERO
                                  : 8'(sps_pkg::CH_ZERO + $urandom_range(9)));
      endcase
    end else begin
      queue_item(1'b1, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    src_idle_pct = 24;
    sink_stall_pct = 83;
    // idle tick, then a full forward run that repeats
    queue_item(1'b0, 8'hFF);
    queue_item(1'b1, sps_pkg::CH_FULL);
    queue_item(1'b1, sps_pkg::CH_ZERO);
    queue_item(1'b1, sps_pkg::CH_FWD);
    repeat (5) queue_item(1'b0, 8'h00);
    // single pass stops after the current sequence
    queue_item(1'b1, sps_pkg::CH_SINGLE);
    repeat (4) queue_item(1'b0, 8'hA5);
    // unrecognised bytes around the digits and at the extremes
    queue_item(1'b1, 8'h00);
    queue_item(1'b1, 8'hFF);
    queue_item(1'b1, 8'h2F);
    queue_item(1'b1, 8'h3A);
    queue_item(1'b1, sps_pkg::CH_NINE);
    queue_item(1'b1, sps_pkg::CH_HALF);
    queue_item(1'b1, sps_pkg::CH_BWD);
    // direction change mid sequence, then mode change and stop
    repeat (3) queue_item(1'b0, 8'h00);
    queue_item(1'b1, sps_pkg::CH_FWD);
    queue_item(1'b1, sps_pkg::CH_WAVE);
    queue_item(1'b1, sps_pkg::CH_ONE);
    queue_item(1'b1, sps_pkg::CH_STOP);
    drain();

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          src_idle_pct = 24;
          sink_stall_pct = 83;
        end
        1: begin
          src_idle_pct = 83;
          sink_stall_pct = 24;
        end
        default: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
      endcase
      repeat (RANDOM_PER_PHASE) queue_random_item();
      drain();
    end

    repeat (8) @(negedge clk);
    $display("run covered %0d ticks and %0d command bytes (%0d unrecognized),",
             ticks_sent, cmds_sent, help_bytes);
    $display("%0d full phase sequences, %0d results checked, %0d mismatches",
             passes_done, results_checked, errors);
    if (errors == 0 && predicted_drive.size() == 0)
      $display("stepper_phase_sequencer regression: pass");
    else
      $display("stepper_phase_sequencer regression: fail");
    $finish;
  end

endmodule
